// ===== rtl/rfpr_pkg.sv =====
// Package: shared constants, types and helpers of the raw frame ping responder.
package rfpr_pkg;

   localparam int NetIdBytesDefault = 4;
   localparam int HeaderBytes       = 17;

   localparam logic [7:0]  PING_UNI_REQ = 8'h00;
   localparam logic [7:0]  PING_UNI_ACK = 8'h01;
   localparam logic [7:0]  PING_BC_REQ  = 8'h02;
   localparam logic [7:0]  PING_BC_ACK  = 8'h03;

   localparam logic [15:0] FRAME_TYPE_RESET = 16'h9001;
   localparam logic [7:0]  BCAST_BYTE       = 8'hff;

   localparam int          CsrIdxW  = 2;
   localparam int          CsrDataW = 48;
   localparam logic [CsrIdxW-1:0] CSR_OWN_MAC    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_TYPE = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_NETWORK_ID = 2'd2;

   typedef struct packed {
      logic [47:0] own_mac;
      logic [15:0] frame_type;
      logic [31:0] network_id;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        bcast;
      logic [47:0] sender_mac;
      logic [15:0] packet_tag;
   } reply_start_type;

   // byte k (wire order) of the network id field; bytes above 32 bits read zero
   function automatic logic [7:0] netid_byte(input logic [31:0] nid, input int unsigned k,
                                             input int unsigned nbytes);
      int unsigned sh;
      logic [7:0]  res;
      sh = 8 * (nbytes - 1 - k);
      if (sh >= 32) begin
         res = 8'h00;
      end else begin
         res = 8'(nid >> sh);
      end
      return res;
   endfunction

endpackage

// ===== rtl/rfpr_if.sv =====
// Interfaces: receive, reply and register write channels.
interface rfpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_last;
   modport source (output valid, rx_byte, rx_last, input ready);
   modport sink   (input valid, rx_byte, rx_last, output ready);
endinterface

interface rfpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic       ping_kind;
   modport source (output valid, tx_byte, tx_last, ping_kind, input ready);
   modport sink   (input valid, tx_byte, tx_last, ping_kind, output ready);
endinterface

interface rfpr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rfpr_pkg::CsrIdxW-1:0]  index;
   logic [rfpr_pkg::CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/raw_frame_ping_responder_unit.sv =====
// Top level of the raw frame ping responder.
// Receive channel req_chan: one frame byte per item, rx_last on the final byte.
// Reply channel rsp_chan: one reply byte per item, tx_last on the final byte,
// ping_kind 0 for a unicast and 1 for a broadcast ping, constant over a reply.
// Register channel csr_chan: index 0 own MAC, 1 frame type, 2 network id;
// always ready. The user must write it only while no frame is in flight; the
// block does not enforce this. Receive bytes are taken one per cycle through
// an input register. A final byte of a qualifying frame starts a reply: it
// passes the input register, the start sets the reply generator busy and the
// first reply byte is then loaded into the output register. The reply runs
// at one byte per cycle while the receiver does not stall, FRAME_LEN = 17 +
// NET_ID_BYTES bytes, paced by the reply counter. Bytes of the next frame are
// taken while a reply is going out; only a final byte waits until the last
// byte of the previous reply has been loaded into the output register. When
// the receiver stalls, the output register holds its byte and the reply
// counter pauses. Reset clears the parser state, empties the input and output
// registers, sets own MAC and network id to zero and frame type to 0x9001.
module raw_frame_ping_responder_unit #(
   parameter int NET_ID_BYTES = rfpr_pkg::NetIdBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   rfpr_req_if.sink   req_chan,
   rfpr_rsp_if.source rsp_chan,
   rfpr_csr_if.sink   csr_chan
);

   rfpr_pkg::cfg_type         cfg;
   rfpr_pkg::reply_start_type start;
   logic                      emit_busy;

   rfpr_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rfpr_parser #(.NET_ID_BYTES(NET_ID_BYTES)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .emit_busy (emit_busy),
      .start     (start)
   );

   rfpr_reply_gen #(.NET_ID_BYTES(NET_ID_BYTES)) u_reply (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .emit_busy (emit_busy),
      .rsp_chan  (rsp_chan)
   );

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> !emit_busy)
      else $error("reply started while a reply is in progress");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(emit_busy) |-> $past(start.valid))
      else $error("reply generator became busy without a start");

   a_reply_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.tx_last) |=>
         (rsp_chan.valid && rsp_chan.ping_kind == $past(rsp_chan.ping_kind)))
      else $error("reply byte missing or ping kind changed within a reply");

endmodule

// ===== rtl/rfpr_csr_regs.sv =====
// Configuration registers: own MAC, frame type and network id.
module rfpr_csr_regs (
   input  logic              clock,
   input  logic              reset,
   rfpr_csr_if.sink          csr_chan,
   output rfpr_pkg::cfg_type cfg
);

   rfpr_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;

   assign csr_chan.ready = 1'b1;
   assign wr             = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_chan.index)
            rfpr_pkg::CSR_OWN_MAC:    cfg_in.own_mac    = csr_chan.data;
            rfpr_pkg::CSR_FRAME_TYPE: cfg_in.frame_type = csr_chan.data[15:0];
            rfpr_pkg::CSR_NETWORK_ID: cfg_in.network_id = csr_chan.data[31:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac    <= '0;
         cfg_ff.frame_type <= rfpr_pkg::FRAME_TYPE_RESET;
         cfg_ff.network_id <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/rfpr_parser.sv =====
// Frame parser: input register, header checks and field capture.
module rfpr_parser #(
   parameter int NET_ID_BYTES = rfpr_pkg::NetIdBytesDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   rfpr_req_if.sink                  req_chan,
   input  rfpr_pkg::cfg_type         cfg,
   input  logic                      emit_busy,
   output rfpr_pkg::reply_start_type start
);

   localparam int FrameLen = rfpr_pkg::HeaderBytes + NET_ID_BYTES;
   localparam int PosW     = $clog2(FrameLen + 1);
   localparam logic [PosW-1:0] PosSrc   = PosW'(6);
   localparam logic [PosW-1:0] PosType  = PosW'(12);
   localparam logic [PosW-1:0] PosType2 = PosW'(13);
   localparam logic [PosW-1:0] PosNid   = PosW'(14);
   localparam logic [PosW-1:0] PosMode  = PosW'(14 + NET_ID_BYTES);
   localparam logic [PosW-1:0] PosEnd   = PosW'(FrameLen);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_last_ff, in_last_in;
   logic            consume, req_acc;

   logic [PosW-1:0] pos_ff, pos_in, pos_n;
   logic            own_ff, own_in, own_n;
   logic            bc_ff, bc_in, bc_n;
   logic [47:0]     sender_ff, sender_in, sender_n;
   logic            hdr_ff, hdr_in, hdr_n;
   logic [7:0]      mode_ff, mode_in, mode_n;
   logic [15:0]     tag_ff, tag_in, tag_n;

   logic [2:0]      mac_idx;
   logic [7:0]      own_byte;
   logic            uni, bro, qualify;

   // a final byte waits while a reply is still going out
   assign consume        = in_valid_ff && !(in_last_ff && emit_busy);
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_acc) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
         in_last_in  = req_chan.rx_last;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   assign mac_idx  = 3'd5 - pos_ff[2:0];
   assign own_byte = 8'(cfg.own_mac >> {mac_idx, 3'b000});

   always_comb begin
      pos_n    = pos_ff;
      own_n    = own_ff;
      bc_n     = bc_ff;
      sender_n = sender_ff;
      hdr_n    = hdr_ff;
      mode_n   = mode_ff;
      tag_n    = tag_ff;
      if (pos_ff < PosSrc) begin
         if (in_byte_ff != own_byte) own_n = 1'b0;
         if (in_byte_ff != rfpr_pkg::BCAST_BYTE) bc_n = 1'b0;
      end else if (pos_ff < PosType) begin
         sender_n = {sender_ff[39:0], in_byte_ff};
      end else if (pos_ff == PosType) begin
         if (in_byte_ff != cfg.frame_type[15:8]) hdr_n = 1'b0;
      end else if (pos_ff == PosType2) begin
         if (in_byte_ff != cfg.frame_type[7:0]) hdr_n = 1'b0;
      end else if (pos_ff < PosMode) begin
         if (in_byte_ff != rfpr_pkg::netid_byte(cfg.network_id,
                                                 32'(pos_ff - PosNid), NET_ID_BYTES))
            hdr_n = 1'b0;
      end else if (pos_ff == PosMode) begin
         mode_n = in_byte_ff;
      end else if (pos_ff < PosEnd) begin
         tag_n = {tag_ff[7:0], in_byte_ff};
      end
      if (pos_ff < PosEnd) pos_n = pos_ff + 1'b1;
   end

   assign uni     = !bc_n && own_n && (mode_n == rfpr_pkg::PING_UNI_REQ);
   assign bro     = bc_n && (mode_n == rfpr_pkg::PING_BC_REQ);
   assign qualify = (pos_n == PosEnd) && hdr_n && (uni || bro);

   always_comb begin
      pos_in    = pos_ff;
      own_in    = own_ff;
      bc_in     = bc_ff;
      sender_in = sender_ff;
      hdr_in    = hdr_ff;
      mode_in   = mode_ff;
      tag_in    = tag_ff;
      if (consume) begin
         if (in_last_ff) begin
            pos_in    = '0;
            own_in    = 1'b1;
            bc_in     = 1'b1;
            sender_in = '0;
            hdr_in    = 1'b1;
            mode_in   = '0;
            tag_in    = '0;
         end else begin
            pos_in    = pos_n;
            own_in    = own_n;
            bc_in     = bc_n;
            sender_in = sender_n;
            hdr_in    = hdr_n;
            mode_in   = mode_n;
            tag_in    = tag_n;
         end
      end
   end

   assign start.valid      = consume && in_last_ff && qualify;
   assign start.bcast      = bro;
   assign start.sender_mac = sender_n;
   assign start.packet_tag = tag_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         own_ff      <= 1'b1;
         bc_ff       <= 1'b1;
         sender_ff   <= '0;
         hdr_ff      <= 1'b1;
         mode_ff     <= '0;
         tag_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         own_ff      <= own_in;
         bc_ff       <= bc_in;
         sender_ff   <= sender_in;
         hdr_ff      <= hdr_in;
         mode_ff     <= mode_in;
         tag_ff      <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule

// ===== rtl/rfpr_reply_gen.sv =====
// Reply generator: holds captured fields; one reply byte per cycle unless stalled.
module rfpr_reply_gen #(
   parameter int NET_ID_BYTES = rfpr_pkg::NetIdBytesDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rfpr_pkg::cfg_type         cfg,
   input  rfpr_pkg::reply_start_type start,
   output logic                      emit_busy,
   rfpr_rsp_if.source                rsp_chan
);

   localparam int FrameLen = rfpr_pkg::HeaderBytes + NET_ID_BYTES;
   localparam int PosW     = $clog2(FrameLen + 1);
   localparam logic [PosW-1:0] PosSrc   = PosW'(6);
   localparam logic [PosW-1:0] PosType  = PosW'(12);
   localparam logic [PosW-1:0] PosType2 = PosW'(13);
   localparam logic [PosW-1:0] PosNid   = PosW'(14);
   localparam logic [PosW-1:0] PosMode  = PosW'(14 + NET_ID_BYTES);
   localparam logic [PosW-1:0] PosTagHi = PosW'(15 + NET_ID_BYTES);
   localparam logic [PosW-1:0] PosLast  = PosW'(FrameLen - 1);

   logic            busy_ff, busy_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [47:0]     sender_ff, sender_in;
   logic [15:0]     tag_ff, tag_in;
   logic            bro_ff, bro_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      tx_byte_ff, tx_byte_in;
   logic            tx_last_ff, tx_last_in;
   logic            kind_ff, kind_in;

   logic            out_load;
   logic [2:0]      mac_idx;
   logic [7:0]      rbyte;

   assign out_load = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign mac_idx  = 3'd5 - (pos_ff < PosSrc ? pos_ff[2:0] : 3'(pos_ff - PosSrc));

   always_comb begin
      if (pos_ff < PosSrc) begin
         rbyte = 8'(sender_ff >> {mac_idx, 3'b000});
      end else if (pos_ff < PosType) begin
         rbyte = 8'(cfg.own_mac >> {mac_idx, 3'b000});
      end else if (pos_ff == PosType) begin
         rbyte = cfg.frame_type[15:8];
      end else if (pos_ff == PosType2) begin
         rbyte = cfg.frame_type[7:0];
      end else if (pos_ff < PosMode) begin
         rbyte = rfpr_pkg::netid_byte(cfg.network_id, 32'(pos_ff - PosNid), NET_ID_BYTES);
      end else if (pos_ff == PosMode) begin
         rbyte = bro_ff ? rfpr_pkg::PING_BC_ACK : rfpr_pkg::PING_UNI_ACK;
      end else if (pos_ff == PosTagHi) begin
         rbyte = tag_ff[15:8];
      end else begin
         rbyte = tag_ff[7:0];
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      pos_in    = pos_ff;
      sender_in = sender_ff;
      tag_in    = tag_ff;
      bro_in    = bro_ff;
      if (start.valid) begin
         busy_in   = 1'b1;
         pos_in    = '0;
         sender_in = start.sender_mac;
         tag_in    = start.packet_tag;
         bro_in    = start.bcast;
      end else if (out_load) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == PosLast) busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      tx_byte_in   = tx_byte_ff;
      tx_last_in   = tx_last_ff;
      kind_in      = kind_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         tx_byte_in   = rbyte;
         tx_last_in   = (pos_ff == PosLast);
         kind_in      = bro_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      sender_ff  <= sender_in;
      tag_ff     <= tag_in;
      bro_ff     <= bro_in;
      tx_byte_ff <= tx_byte_in;
      tx_last_ff <= tx_last_in;
      kind_ff    <= kind_in;
   end

   assign emit_busy          = busy_ff;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.tx_byte   = tx_byte_ff;
   assign rsp_chan.tx_last   = tx_last_ff;
   assign rsp_chan.ping_kind = kind_ff;

endmodule
